FILE: hdl/best_fit_id_range_allocator_defines.svh
// Assertion macros for the best-fit ID range allocator.
// No dependencies.
`ifndef BEST_FIT_ID_RANGE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_ID_RANGE_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("bfa check");
`define BFA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("bfa reset check");
`else
`define BFA_ASSERT(lbl, prop)
`define BFA_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: hdl/bfa_pkg.sv
// Shared types and constants for the best-fit ID range allocator.
// No dependencies.
`default_nettype none
package bfa_pkg;
  localparam int unsigned IdW = 24;
  localparam int unsigned CapW = 25;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_FULL    = 2'd2,
    ST_EXHAUST = 2'd3
  } status_e;

  // Entry contents circulating through the cell chain.
  typedef struct packed {
    logic [IdW-1:0]  first;
    logic [CapW-1:0] cap;
    logic [CapW-1:0] used;
    logic            rel;
    logic [31:0]     stamp;
  } entry_t;

  // Per-item control broadcast to every cell.
  typedef struct packed {
    logic            wr_new;
    logic            wr_rel;
    logic [CapW-1:0] size;
    logic [IdW-1:0]  first;
    logic [31:0]     stamp;
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: hdl/best_fit_id_range_allocator.sv
// Best-fit ID range allocator top level: handshake, sequencer, rotating chain of entry cells.
// Depends on bfa_pkg, bfa_cell, bfa_decode and the defines header.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | opcode, req_size, entry_handle, pick_color
//  out     | out | out_valid/out_ready| status, result_handle, range_start, picked_offset,
//          |     |                    | hit_is_free
//
// Each item is accepted, passes a decode state, then the entry chain rotates
// once through all cells (one entry inspected per cycle at the chain head),
// then commits once the output register is free. Release with a bad handle
// still runs the full scan.
// Reset clears control, entry count, counters and every entry cell. The result
// sits in an output register; a new item is taken while it waits, but the next
// result waits for it to drain.
`default_nettype none
`include "best_fit_id_range_allocator_defines.svh"
module best_fit_id_range_allocator import bfa_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     opcode_i,
  input  wire logic [23:0]    req_size_i,
  input  wire logic [5:0]     entry_handle_i,
  input  wire logic [23:0]    pick_color_i,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          status_o,
  output logic [5:0]          result_handle_o,
  output logic [23:0]         range_start_o,
  output logic [23:0]         picked_offset_o,
  output logic                hit_is_free_o
);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {S_IDLE, S_DEC, S_SCAN, S_DONE} state_e;

  state_e          state_q;
  logic [1:0]      op_q;
  logic [CapW-1:0] size_q;
  logic [5:0]      handle_q;
  logic [AW:0]     cnt_q;        // rotation position, counts to MAX_ENTRIES
  logic [CW-1:0]   ecount_q;
  logic [CapW-1:0] next_id_q;
  logic [31:0]     relctr_q;
  logic            found_q;
  logic [AW-1:0]   best_q;
  logic [CapW-1:0] best_cap_q;
  logic [31:0]     best_age_q;
  logic [IdW-1:0]  best_first_q;
  logic            best_rel_q;
  logic [IdW-1:0]  id_q;
  logic            neg_q;

  logic            ov_q;
  logic [1:0]      st_q;
  logic [5:0]      rh_q;
  logic [23:0]     rs_q, po_q;
  logic            hf_q;

  entry_t          ent [MAX_ENTRIES];
  logic            shift;
  logic [AW-1:0]   wr_idx;
  logic            wr_go;
  cell_ctl_t       ctl;
  logic            dec_neg;
  logic [IdW-1:0]  dec_id;

  // Cell k holds entry (k + cnt) mod N while rotating; head is cell 0.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    bfa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .wr_i   (wr_go && (wr_idx == AW'(k))),
      .ctl_i  (ctl),
      .prev_i (ent[(k + 1) % MAX_ENTRIES]),
      .ent_o  (ent[k])
    );
  end

  // Decoder registers the colour at the accepting edge; its result is taken
  // into id_q during the decode cycle.
  bfa_decode u_dec (
    .clk_i  (clk_i),
    .color_i(pick_color_i),
    .neg_o  (dec_neg),
    .id_o   (dec_id)
  );

  entry_t          head;
  logic [AW-1:0]   head_idx;
  logic            head_live;
  logic [31:0]     head_age;
  logic            cand, hit;
  logic [CapW-1:0] id_ext, fs_ext;

  assign head      = ent[0];
  assign head_idx  = cnt_q[AW-1:0];
  assign head_live = (CW'(cnt_q) < ecount_q);
  assign head_age  = relctr_q - head.stamp;
  assign cand = head_live && head.rel && (head.cap >= size_q);
  assign id_ext = {1'b0, id_q};
  assign fs_ext = {1'b0, head.first};
  assign hit  = head_live && !neg_q && (id_ext >= fs_ext) && (id_ext < fs_ext + head.used);
  assign shift = (state_q == S_SCAN);

  logic rel_ok, new_ok, full, exh;
  assign rel_ok = (CW'(handle_q) < ecount_q) && (32'(handle_q) < MAX_ENTRIES) &&
                  !ent[AW'(handle_q)].rel;
  assign full   = (ecount_q == CW'(MAX_ENTRIES));
  assign exh    = (next_id_q + size_q) > CapW'(25'h1000000);
  assign new_ok = !found_q && !full && !exh;

  always_comb begin
    ctl        = '0;
    ctl.size   = size_q;
    ctl.first  = next_id_q[IdW-1:0];
    ctl.stamp  = relctr_q;
    wr_idx     = best_q;
    wr_go      = 1'b0;
    if (state_q == S_DONE && !ov_q) begin
      case (op_q)
        OP_ALLOC: begin
          wr_go      = found_q || new_ok;
          ctl.wr_new = !found_q;
          wr_idx     = found_q ? best_q : AW'(ecount_q);
        end
        OP_RELEASE: begin
          wr_go      = rel_ok;
          ctl.wr_rel = 1'b1;
          wr_idx     = AW'(handle_q);
        end
        default: ;
      endcase
    end
  end

  // Result fields for the item being committed.
  status_e     res_st;
  logic [5:0]  res_rh;
  logic [23:0] res_rs, res_po;
  logic        res_hf;

  always_comb begin
    res_st = ST_MISS;
    res_rh = '0;
    res_rs = '0;
    res_po = '0;
    res_hf = 1'b0;
    case (op_q)
      OP_ALLOC: begin
        if (found_q) begin
          res_st = ST_OK;
          res_rh = 6'(best_q);
          res_rs = best_first_q;
        end else if (full) begin
          res_st = ST_FULL;
        end else if (exh) begin
          res_st = ST_EXHAUST;
        end else begin
          res_st = ST_OK;
          res_rh = 6'(ecount_q);
          res_rs = next_id_q[IdW-1:0];
        end
      end
      OP_RELEASE: if (rel_ok) begin
        res_st = ST_OK;
        res_rh = handle_q;
        res_rs = ent[AW'(handle_q)].first;
      end
      OP_LOOKUP: if (found_q) begin
        res_st = ST_OK;
        res_rh = 6'(best_q);
        res_rs = best_first_q;
        res_po = id_q - best_first_q;
        res_hf = best_rel_q;
      end
      default: ;
    endcase
  end

  assign in_ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ecount_q  <= '0;
      next_id_q <= '0;
      relctr_q  <= '0;
      ov_q      <= 1'b0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
    end else begin
      if (ov_q && out_ready) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_valid) begin
          op_q     <= opcode_i;
          size_q   <= {1'b0, req_size_i};
          handle_q <= entry_handle_i;
          cnt_q    <= '0;
          found_q  <= 1'b0;
          state_q  <= S_DEC;
        end
        S_DEC: begin
          id_q    <= dec_id;
          neg_q   <= dec_neg;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (op_q == OP_ALLOC && cand && (!found_q || head.cap < best_cap_q ||
              (head.cap == best_cap_q && head_age > best_age_q))) begin
            found_q      <= 1'b1;
            best_q       <= head_idx;
            best_cap_q   <= head.cap;
            best_age_q   <= head_age;
            best_first_q <= head.first;
          end
          if (op_q == OP_LOOKUP && hit && !found_q) begin
            found_q      <= 1'b1;
            best_q       <= head_idx;
            best_first_q <= head.first;
            best_rel_q   <= head.rel;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (AW+1)'(MAX_ENTRIES - 1)) state_q <= S_DONE;
        end
        S_DONE: if (!ov_q) begin
          ov_q    <= 1'b1;
          st_q    <= res_st;
          rh_q    <= res_rh;
          rs_q    <= res_rs;
          po_q    <= res_po;
          hf_q    <= res_hf;
          state_q <= S_IDLE;
          if (op_q == OP_ALLOC && new_ok) begin
            next_id_q <= next_id_q + size_q;
            ecount_q  <= ecount_q + 1'b1;
          end
          if (op_q == OP_RELEASE && rel_ok) begin
            relctr_q <= relctr_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = ov_q;
  assign status_o        = st_q;
  assign result_handle_o = rh_q;
  assign range_start_o   = rs_q;
  assign picked_offset_o = po_q;
  assign hit_is_free_o   = hf_q;

  `BFA_ASSERT(a_cnt_range, cnt_q <= (AW+1)'(MAX_ENTRIES))
  `BFA_ASSERT(a_ecount_range, ecount_q <= CW'(MAX_ENTRIES))
  `BFA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status_o))
  `BFA_ASSERT(a_no_write_busy, wr_go |-> state_q == S_DONE)
endmodule
`default_nettype wire

FILE: hdl/bfa_cell.sv
// One cell of the rotating entry chain: holds one entry, passes it on when shifting.
// Depends on bfa_pkg.
`default_nettype none
module bfa_cell import bfa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      shift_i,
  input  wire logic      wr_i,
  input  wire cell_ctl_t ctl_i,
  input  wire entry_t    prev_i,
  output entry_t         ent_o
);
  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (wr_i) begin
      if (ctl_i.wr_new) begin
        ent_d.first = ctl_i.first;
        ent_d.cap   = ctl_i.size;
        ent_d.used  = ctl_i.size;
        ent_d.rel   = 1'b0;
      end else if (ctl_i.wr_rel) begin
        ent_d.rel   = 1'b1;
        ent_d.stamp = ctl_i.stamp;
      end else begin
        ent_d.rel   = 1'b0;
        ent_d.used  = ctl_i.size;
      end
    end else if (shift_i) begin
      ent_d = prev_i;
    end
  end

  // whole cell clears on reset; released flag must start low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;
endmodule
`default_nettype wire

FILE: hdl/bfa_decode.sv
// Registered colour-to-ID decoder (13-stripe scheme, exact integer form).
// Depends on bfa_pkg.
`default_nettype none
module bfa_decode import bfa_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic [IdW-1:0] color_i,
  output logic                neg_o,
  output logic [IdW-1:0]      id_o
);
  logic [28:0] prod;
  logic [3:0]  i_q;
  logic [IdW-1:0] n_q;
  logic [IdW:0]   base;
  logic signed [31:0] o_s, id_s;

  assign prod = 29'(color_i) * 29'd13 + 29'(24'h800000);
  always_ff @(posedge clk_i) begin
    i_q <= prod[27:24];
    n_q <= color_i;
  end
  // base = floor((i*2^24 + 6)/13), i <= 13; since 2^24 = 13*1290555 + 1 this is
  // i*1290555 plus one once i reaches 7
  assign base = 25'(i_q) * 25'd1290555 + {24'd0, (i_q >= 4'd7)};
  assign o_s  = $signed({8'd0, n_q}) - $signed({7'd0, base});
  assign id_s = o_s * 32'sd13 + $signed({28'd0, i_q}) - 32'sd1;
  assign neg_o = id_s[31];
  assign id_o  = id_s[IdW-1:0];
endmodule
`default_nettype wire

FILE: tb/best_fit_id_range_allocator_tb.sv
// Self-checking testbench for the best-fit ID range allocator.
// Depends on bfa_pkg and the best_fit_id_range_allocator RTL.
`default_nettype none
module best_fit_id_range_allocator_tb import bfa_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 64;
  localparam int unsigned IdSpace    = 1 << 24;
  localparam int unsigned Stripes    = 13;
  localparam int unsigned HoldCycles = 300;  // long receiver hold-off
  localparam int unsigned StallLimit = 3000; // cycles with no handshake
  localparam int unsigned DrainWait  = 2 * (NumEntries + 3);

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode_i = OP_ALLOC;
  logic [23:0] req_size_i = '0;
  logic [5:0]  entry_handle_i = '0;
  logic [23:0] pick_color_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  result_handle_o;
  logic [23:0] range_start_o;
  logic [23:0] picked_offset_o;
  logic        hit_is_free_o;

  best_fit_id_range_allocator #(.MAX_ENTRIES(NumEntries)) u_top (
    .clk_i, .rst_ni, .in_valid, .in_ready, .opcode_i, .req_size_i, .entry_handle_i,
    .pick_color_i, .out_valid, .out_ready, .status_o, .result_handle_o, .range_start_o,
    .picked_offset_o, .hit_is_free_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  typedef struct packed {
    status_e     status;
    logic [5:0]  handle;
    logic [23:0] start;
    logic [23:0] offset;
    logic        is_free;
  } alloc_reply_t;

  alloc_reply_t reply_q[$];
  int unsigned  mismatches = 0;
  bit           hold_req = 1'b0;

  // Shadow copy of the allocator table.
  logic [23:0] tbl_first [NumEntries];
  logic [24:0] tbl_cap   [NumEntries];
  logic [24:0] tbl_used  [NumEntries];
  bit          tbl_rel   [NumEntries];
  logic [31:0] tbl_stamp [NumEntries];
  logic [31:0] rel_count = '0;
  logic [24:0] next_id = '0;
  int unsigned live_count = 0;

  // Integer form of the stripe decoder; negative means no valid ID.
  function automatic longint decode_pick_id(logic [23:0] color);
    longint i, base, o;
    i    = (longint'(color) * Stripes + (IdSpace / 2)) >>> 24;
    base = (i * IdSpace + 6) / Stripes;
    o    = longint'(color) - base;
    return o * Stripes + i - 1;
  endfunction

  // Inverse used for stimulus only: a colour that should decode to id.
  function automatic logic [23:0] encode_pick_id(longint id);
    longint v, n;
    v = id + 1;
    n = ((v % Stripes) * IdSpace + 6) / Stripes + v / Stripes;
    return (n > 24'hFFFFFF) ? 24'($urandom) : 24'(n);
  endfunction

  function automatic alloc_reply_t predict_reply(op_e op, logic [23:0] size,
                                                 logic [5:0] h, logic [23:0] color);
    alloc_reply_t r;
    bit found;
    int unsigned best;
    logic [24:0] best_cap;
    logic [31:0] best_age, age;
    longint id;
    r = '{ST_MISS, '0, '0, '0, 1'b0};
    case (op)
      OP_ALLOC: begin
        found = 1'b0;
        best = 0;
        best_cap = '0;
        best_age = '0;
        for (int k = 0; k < live_count; k++) begin
          if (tbl_rel[k] && tbl_cap[k] >= {1'b0, size}) begin
            age = rel_count - tbl_stamp[k];
            if (!found || tbl_cap[k] < best_cap || (tbl_cap[k] == best_cap && age > best_age))
            begin
              found = 1'b1;
              best = k;
              best_cap = tbl_cap[k];
              best_age = age;
            end
          end
        end
        if (found) begin
          tbl_rel[best] = 1'b0;
          tbl_used[best] = {1'b0, size};
          r = '{ST_OK, 6'(best), tbl_first[best], '0, 1'b0};
        end else if (live_count >= NumEntries) begin
          r.status = ST_FULL;
        end else if (26'(next_id) + 26'(size) > 26'(IdSpace)) begin
          r.status = ST_EXHAUST;
        end else begin
          tbl_first[live_count] = next_id[23:0];
          tbl_cap[live_count] = {1'b0, size};
          tbl_used[live_count] = {1'b0, size};
          tbl_rel[live_count] = 1'b0;
          r = '{ST_OK, 6'(live_count), next_id[23:0], '0, 1'b0};
          next_id = next_id + size;
          live_count++;
        end
      end
      OP_RELEASE: begin
        if (h < live_count && !tbl_rel[h]) begin
          tbl_rel[h] = 1'b1;
          tbl_stamp[h] = rel_count;
          rel_count = rel_count + 1;
          r = '{ST_OK, h, tbl_first[h], '0, 1'b0};
        end
      end
      OP_LOOKUP: begin
        id = decode_pick_id(color);
        if (id >= 0) begin
          for (int k = 0; k < live_count; k++) begin
            if (id >= tbl_first[k] && id < longint'(tbl_first[k]) + tbl_used[k]) begin
              r = '{ST_OK, 6'(k), tbl_first[k], 24'(id - tbl_first[k]), tbl_rel[k]};
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item after a random gap; returns once it is accepted.
  task automatic send_item(op_e op, logic [23:0] size, logic [5:0] h, logic [23:0] color);
    int unsigned gap;
    bit rdy;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode_i <= op;
    req_size_i <= size;
    entry_handle_i <= h;
    pick_color_i <= color;
    do begin
      @(negedge clk_i);
      rdy = in_ready;
      @(posedge clk_i);
    end while (!rdy);
    reply_q = {reply_q, predict_reply(op, size, h, color)};
  endtask

  function automatic logic [24:0] max_free_cap();
    logic [24:0] m;
    m = '0;
    for (int k = 0; k < live_count; k++)
      if (tbl_rel[k] && tbl_cap[k] > m) m = tbl_cap[k];
    return m;
  endfunction

  // Random item biased toward meaningful traffic: live handles, hitting colours.
  task automatic send_random_item();
    int unsigned pick, k;
    logic [23:0] sz, col;
    logic [5:0] h;
    pick = $urandom_range(0, 99);
    sz = 24'($urandom_range(0, 15));
    h = 6'($urandom);
    col = 24'($urandom);
    if (pick < 3) begin
      send_item(OP_NONE, 24'($urandom), h, col);
    end else if (pick < 38) begin
      k = $urandom_range(0, 9);
      if (k == 0) sz = 24'($urandom);
      else if (k < 3 && live_count > 0) sz = tbl_cap[$urandom_range(0, live_count - 1)][23:0];
      send_item(OP_ALLOC, sz, h, col);
    end else if (pick < 65) begin
      if (live_count > 0 && $urandom_range(0, 9) < 7) h = 6'($urandom_range(0, live_count - 1));
      send_item(OP_RELEASE, sz, h, col);
    end else begin
      if (live_count > 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, live_count - 1);
        if (tbl_used[k] != 0)
          col = encode_pick_id(longint'(tbl_first[k]) + $urandom_range(0, tbl_used[k] - 1));
      end
      send_item(OP_LOOKUP, sz, h, col);
    end
  endtask

  // Withdraw the offer, then wait for every expected result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, every opcode, bad releases, zero size and exhaustion.
  task automatic test_directed_edges();
    send_item(OP_LOOKUP, '0, '0, 24'h000000);       // empty table
    send_item(OP_ALLOC, 24'd0, '0, '0);             // zero-size entry
    send_item(OP_ALLOC, 24'd5, '0, '0);
    send_item(OP_ALLOC, 24'hFFFFFF, '0, '0);        // exhausts space
    send_item(OP_ALLOC, 24'd40, 6'h3F, 24'hFFFFFF);
    send_item(OP_RELEASE, '0, 6'h3F, '0);           // handle past the table
    send_item(OP_RELEASE, '0, 6'd1, '0);
    send_item(OP_RELEASE, '0, 6'd1, '0);            // already released
    send_item(OP_LOOKUP, '0, '0, encode_pick_id(3)); // hit on freed entry
    send_item(OP_LOOKUP, '0, '0, encode_pick_id(20));
    send_item(OP_LOOKUP, '0, '0, 24'hFFFFFF);
    send_item(OP_RELEASE, '0, 6'd2, '0);
    send_item(OP_ALLOC, 24'd4, '0, '0);             // best fit picks cap 5
    send_item(OP_RELEASE, '0, 6'd0, '0);
    send_item(OP_ALLOC, 24'd0, '0, '0);             // zero size reuses any freed
    send_item(OP_NONE, 24'hFFFFFF, 6'h3F, 24'hFFFFFF);
    send_item(OP_ALLOC, 24'd7, '0, '0);
    send_item(OP_ALLOC, 24'd7, '0, '0);
    send_item(OP_RELEASE, '0, 6'd4, '0);
    send_item(OP_RELEASE, '0, 6'd3, '0);
    send_item(OP_ALLOC, 24'd7, '0, '0);             // reuses the only freed entry, cap 7
  endtask

  task automatic test_random_mix(int unsigned n);
    repeat (n) send_random_item();
  endtask

  // Receiver stalls long while the sender keeps offering.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (20) send_random_item();
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (20) send_random_item();
  endtask

  // Fill up to the exact end of the ID space, then run into the table limit.
  task automatic test_space_limits();
    logic [25:0] rem;
    for (int n = 0; n < 70 && live_count < 62; n++)
      send_item(OP_ALLOC, 24'(max_free_cap() + 1), '0, '0);
    rem = 26'(IdSpace) - 26'(next_id);
    if (live_count < NumEntries && rem > 26'(max_free_cap()) && rem <= 26'hFFFFFF) begin
      send_item(OP_ALLOC, rem[23:0], '0, '0);
      send_item(OP_ALLOC, 24'(max_free_cap() + 1), '0, '0);
    end
    for (int n = 0; n < 70 && live_count < NumEntries; n++)
      send_item(OP_ALLOC, 24'd0, '0, '0);
    send_item(OP_ALLOC, 24'(max_free_cap() + 1), '0, '0);
    send_item(OP_LOOKUP, '0, '0, encode_pick_id(IdSpace - 1));
  endtask

  // Receiver and checker: random stall per result, long hold on request.
  initial begin : rx_check
    int unsigned stall;
    bit got;
    alloc_reply_t act, exp_r;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = $urandom_range(0, 7);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk_i);
        got = out_valid;
        act = '{status_e'(status_o), result_handle_o, range_start_o, picked_offset_o,
                hit_is_free_o};
        @(posedge clk_i);
      end while (!got);
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, act);
        mismatches++;
      end else begin
        exp_r = reply_q.pop_front();
        if (act.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, act.status);
          mismatches++;
        end
        if (act.handle !== exp_r.handle) begin
          $display("%0t: handle expected %0d actual %0d", $realtime, exp_r.handle, act.handle);
          mismatches++;
        end
        if (act.start !== exp_r.start) begin
          $display("%0t: range_start expected %0h actual %0h", $realtime, exp_r.start,
                   act.start);
          mismatches++;
        end
        if (act.offset !== exp_r.offset) begin
          $display("%0t: offset expected %0h actual %0h", $realtime, exp_r.offset, act.offset);
          mismatches++;
        end
        if (act.is_free !== exp_r.is_free) begin
          $display("%0t: hit_is_free expected %0b actual %0b", $realtime, exp_r.is_free,
                   act.is_free);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : main
    for (int k = 0; k < NumEntries; k++) tbl_rel[k] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_random_mix(400);
    test_backpressure();
    test_drain_pause();
    test_random_mix(400);
    test_space_limits();
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
